// ===== sv/npr_pkg.sv =====
// Package for the normalized difference index core: widths, payload types and cell data.
package npr_pkg;

  localparam int BandBits   = 16;
  localparam int PixelBits  = 16;
  localparam int ScaleBits  = 16;
  localparam int IndexBits  = 8;
  localparam int MagBits    = PixelBits + 1;
  localparam int ProdBits   = PixelBits + ScaleBits;
  localparam int RemBits    = PixelBits + 1;
  localparam int HighBits   = ProdBits - IndexBits;
  localparam int NumCells   = IndexBits;
  localparam int Latency    = NumCells + 4;

  localparam logic [ScaleBits-1:0] ScaleReset = ScaleBits'(255);
  localparam logic [IndexBits-1:0] IndexMax   = IndexBits'(255);

  typedef struct packed {
    logic signed [BandBits-1:0] first_band;
    logic signed [BandBits-1:0] second_band;
    logic                       row_end;
  } pixel_in_t;

  typedef struct packed {
    logic [IndexBits-1:0] index_value;
    logic                 row_end_out;
  } index_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 force_zero;
    logic                 sat;
    logic                 row_end;
    logic [RemBits-1:0]   rem;
    logic [RemBits-1:0]   divisor;
    logic [IndexBits-1:0] bits;
  } cell_t;

endpackage

// ===== sv/npr_front.sv =====
// Front end: band difference and sum, zero detect, scaling product and saturation check.
module npr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  npr_pkg::pixel_in_t             pixel_i,
  input  logic [npr_pkg::ScaleBits-1:0]  scale_i,
  output npr_pkg::cell_t                 cell_o
);

  logic signed [npr_pkg::PixelBits:0]   b1, b2, diff, sum;
  logic [npr_pkg::PixelBits:0]          diff_abs, sum_abs;
  logic [npr_pkg::PixelBits-1:0]        dmag_d;
  logic [npr_pkg::MagBits-1:0]          smag_d;
  logic                                 zero_d;

  logic                                 s0_valid_q, s1_valid_q, s2_valid_q;
  logic                                 s0_zero_q, s1_zero_q, s2_zero_q;
  logic                                 s0_row_end_q, s1_row_end_q, s2_row_end_q;
  logic [npr_pkg::PixelBits-1:0]        s0_dmag_q;
  logic [npr_pkg::MagBits-1:0]          s0_smag_q, s1_smag_q;
  logic [npr_pkg::ProdBits-1:0]         prod_d, s1_prod_q;
  logic                                 sat_d, s2_sat_q;
  logic [npr_pkg::RemBits-1:0]          s2_rem_q, s2_div_q;
  logic [npr_pkg::IndexBits-1:0]        s2_bits_q;

  always_comb begin
    b1       = {pixel_i.first_band[npr_pkg::PixelBits-1],
                pixel_i.first_band[npr_pkg::PixelBits-1:0]};
    b2       = {pixel_i.second_band[npr_pkg::PixelBits-1],
                pixel_i.second_band[npr_pkg::PixelBits-1:0]};
    diff     = b2 - b1;
    sum      = b2 + b1;
    diff_abs = diff[npr_pkg::PixelBits] ? -diff : diff;
    sum_abs  = sum[npr_pkg::PixelBits] ? -sum : sum;
    dmag_d   = diff_abs[npr_pkg::PixelBits-1:0];
    smag_d   = sum_abs;
    zero_d   = (sum == '0) || (diff[npr_pkg::PixelBits] ^ sum[npr_pkg::PixelBits]);
  end

  assign prod_d = npr_pkg::ProdBits'(s0_dmag_q) * npr_pkg::ProdBits'(scale_i);
  assign sat_d  = s1_prod_q[npr_pkg::ProdBits-1:npr_pkg::IndexBits] >=
                  npr_pkg::HighBits'(s1_smag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept_i;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_zero_q    <= zero_d;
    s0_row_end_q <= pixel_i.row_end;
    s0_dmag_q    <= dmag_d;
    s0_smag_q    <= smag_d;
    s1_zero_q    <= s0_zero_q;
    s1_row_end_q <= s0_row_end_q;
    s1_smag_q    <= s0_smag_q;
    s1_prod_q    <= prod_d;
    s2_zero_q    <= s1_zero_q;
    s2_row_end_q <= s1_row_end_q;
    s2_sat_q     <= sat_d;
    s2_rem_q     <= s1_prod_q[npr_pkg::IndexBits +: npr_pkg::RemBits];
    s2_div_q     <= npr_pkg::RemBits'(s1_smag_q);
    s2_bits_q    <= s1_prod_q[npr_pkg::IndexBits-1:0];
  end

  always_comb begin
    cell_o.valid      = s2_valid_q;
    cell_o.force_zero = s2_zero_q;
    cell_o.sat        = s2_sat_q;
    cell_o.row_end    = s2_row_end_q;
    cell_o.rem        = s2_rem_q;
    cell_o.divisor    = s2_div_q;
    cell_o.bits       = s2_bits_q;
  end

endmodule

// ===== sv/npr_cell.sv =====
// Divider cell: one restoring quotient bit per stage.
module npr_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  npr_pkg::cell_t cell_i,
  output npr_pkg::cell_t cell_o
);

  logic [npr_pkg::RemBits:0]     trial;
  logic [npr_pkg::RemBits:0]     diff;
  logic                          ge;
  logic [npr_pkg::RemBits-1:0]   rem_d, rem_q, div_q;
  logic [npr_pkg::IndexBits-1:0] bits_d, bits_q;
  logic                          valid_q, zero_q, sat_q, row_end_q;

  always_comb begin
    trial  = {cell_i.rem, cell_i.bits[npr_pkg::IndexBits-1]};
    diff   = trial - {1'b0, cell_i.divisor};
    ge     = trial >= {1'b0, cell_i.divisor};
    rem_d  = ge ? diff[npr_pkg::RemBits-1:0] : trial[npr_pkg::RemBits-1:0];
    bits_d = {cell_i.bits[npr_pkg::IndexBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q    <= cell_i.force_zero;
    sat_q     <= cell_i.sat;
    row_end_q <= cell_i.row_end;
    rem_q     <= rem_d;
    div_q     <= cell_i.divisor;
    bits_q    <= bits_d;
  end

  always_comb begin
    cell_o.valid      = valid_q;
    cell_o.force_zero = zero_q;
    cell_o.sat        = sat_q;
    cell_o.row_end    = row_end_q;
    cell_o.rem        = rem_q;
    cell_o.divisor    = div_q;
    cell_o.bits       = bits_q;
  end

`ifndef NO_ASSERTIONS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_i.valid && !cell_i.force_zero && !cell_i.sat |=> rem_q < div_q)
    else $error("partial remainder not below divisor");
`endif

endmodule

// ===== sv/ndvi_pixel_ratio_core.sv =====
// Top level: scale register, front end, divider cell chain and result register.
// A transfer passes front-end registers s0, s1, s2, the divider cells and the done/result register.
// Throughput: one pixel pair per cycle; busy stays low; the divider chain has 8 cells.
// Each cell resolves one quotient bit.
// Reset clears all valid flags and loads scale_q with 255; the receiver cannot stall.
module ndvi_pixel_ratio_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  npr_pkg::pixel_in_t             pixel_i,
  output logic                           done_o,
  output npr_pkg::index_out_t            result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [npr_pkg::ScaleBits-1:0]  cfg_data_i
);

  logic [npr_pkg::ScaleBits-1:0] scale_q;
  npr_pkg::cell_t                chain [npr_pkg::NumCells+1];
  npr_pkg::cell_t                last;
  logic                          done_q;
  npr_pkg::index_out_t           res_d, res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= npr_pkg::ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  npr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .pixel_i  (pixel_i),
    .scale_i  (scale_q),
    .cell_o   (chain[0])
  );

  for (genvar i = 0; i < npr_pkg::NumCells; i++) begin : g_cell
    npr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign last = chain[npr_pkg::NumCells];

  always_comb begin
    res_d.row_end_out = last.row_end;
    if (last.force_zero) begin
      res_d.index_value = '0;
    end else if (last.sat) begin
      res_d.index_value = npr_pkg::IndexMax;
    end else begin
      res_d.index_value = last.bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##12 done_o)
    else $error("result missing after transfer");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 12))
    else $error("result without matching transfer");
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.row_end_out == $past(pixel_i.row_end, 12))
    else $error("row end flag mismatch");
`endif

endmodule
